[rtl/idba_pkg.sv]
// ----------------------------------------------------------------------------
// idba_pkg
// Shared types and codes for the bitmap id allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package idba_pkg;

  localparam int WORD_BITS    = 64;
  localparam int BIT_SEL_BITS = 6;

  // command codes
  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_ALLOC    = 3'd1;
  localparam logic [2:0] CMD_ALLOC_AT = 3'd2;
  localparam logic [2:0] CMD_FREE     = 3'd3;
  localparam logic [2:0] CMD_QUERY    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT    = 3'd1;
  localparam logic [2:0] ST_NOT_ENOUGH   = 3'd2;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd3;
  localparam logic [2:0] ST_OCCUPIED     = 3'd4;

  // configuration register indexes
  localparam logic REG_ID_BASE  = 1'b0;
  localparam logic REG_ID_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_RESP,
    S_BIT_RD,
    S_BIT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PICK_RD,
    S_PICK_LD,
    S_PICK
  } state_t;

endpackage

`default_nettype wire

[rtl/idba_ram.sv]
// ----------------------------------------------------------------------------
// idba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module idba_ram #(
  parameter int WIDTH     = 64,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/id_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// id_bitmap_allocator_unit
// Id allocator over a free bitmap held in a word RAM (set bit = id free).
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    command, count, target_id,
//                                             start_taken
//  out      output     out_valid / out_ready  status, granted_id, id_is_free,
//                                             last
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// One item at a time; each map word costs a registered RAM read.
// Init writes every map word, then responds. Alloc specified / free / query:
// read the word, check or update the bit, respond. Alloc batch: scan words
// until enough free ids are seen (else respond), then per word touched read,
// grant ids, write back; a rejected count responds at once. Reset's clearing
// pass fills the map with ones, in_ready low meanwhile. A stalled result holds
// in the output register as the next item is taken; others wait on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module id_bitmap_allocator_unit
  import idba_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int MAX_BATCH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [4:0]  count,
  input  wire logic [31:0] target_id,
  input  wire logic        start_taken,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      granted_id,
  output logic             id_is_free,
  output logic             last,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WCW    = $clog2(NWORDS + 1);
  localparam int MW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);

  function automatic logic [WORD_BITS-1:0] word_mask(input logic [31:0] rem);
    logic [WORD_BITS-1:0] m;
    if (rem >= 32'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (64'd1 << rem[BIT_SEL_BITS-1:0]) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [BIT_SEL_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] x);
    logic [BIT_SEL_BITS-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        p = BIT_SEL_BITS'(i);
      end
    end
    return p;
  endfunction

  state_t state, state_next;

  logic [31:0]             id_base;
  logic [10:0]             id_count;
  logic [MW-1:0]           free_total;

  logic                    fill_reset;
  logic [2:0]              cmd_q;
  logic [4:0]              cnt_q;
  logic                    taken_q;
  logic [IW-1:0]           idx_q;
  logic [WCW-1:0]          w;
  logic [6:0]              acc;
  logic [4:0]              remaining;
  logic [WORD_BITS-1:0]    orig;
  logic [WORD_BITS-1:0]    avail;
  logic [2:0]              resp_status;
  logic                    resp_free;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [WORD_BITS-1:0]    mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [WORD_BITS-1:0]    mem_rdata;

  logic                    emit;
  logic [2:0]              emit_status;
  logic [31:0]             emit_gid;
  logic                    emit_free;
  logic                    emit_last;

  logic [MW-1:0]           managed;
  logic [31:0]             word_base;
  logic [31:0]             rem;
  logic [WORD_BITS-1:0]    cur_mask;
  logic [6:0]              scan_sum;
  logic [BIT_SEL_BITS-1:0] pick_pos;
  logic                    can_emit;
  logic                    in_fire;
  logic [32:0]             diff;
  logic                    in_range;
  logic                    bad_count;
  logic                    short_total;
  logic [BIT_SEL_BITS-1:0] bit_sel;
  logic [AW-1:0]           bit_word;
  logic                    cur_bit;
  logic [WORD_BITS-1:0]    bit_onehot;
  logic                    last_word;
  logic                    scan_beyond;
  logic                    scan_enough;
  logic                    pick_go;

  idba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign managed     = (32'(id_count) > 32'(CAPACITY)) ? MW'(CAPACITY) : MW'(id_count);
  assign word_base   = 32'(w) << BIT_SEL_BITS;
  assign rem         = (32'(managed) > word_base) ? (32'(managed) - word_base) : 32'd0;
  assign cur_mask    = word_mask(rem);
  assign scan_sum    = acc + 7'($countones(mem_rdata & cur_mask));
  assign pick_pos    = lowest_set(avail);
  assign can_emit    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  // range check without wrap
  assign diff        = {1'b0, target_id} - {1'b0, id_base};
  assign in_range    = !diff[32] && (diff[31:0] < 32'(managed));
  assign bad_count   = (count == 5'd0) || (32'(count) > 32'(MAX_BATCH));
  assign short_total = 32'(count) > 32'(free_total);
  assign bit_sel     = idx_q[BIT_SEL_BITS-1:0];
  assign bit_word    = AW'(32'(idx_q) >> BIT_SEL_BITS);
  assign cur_bit     = mem_rdata[bit_sel];
  assign bit_onehot  = 64'd1 << bit_sel;
  assign last_word   = (w == WCW'(NWORDS - 1));
  assign scan_beyond = word_base >= 32'(managed);
  assign scan_enough = scan_sum >= {2'b00, cnt_q};
  assign pick_go     = (remaining != 5'd0) && (avail != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (last_word) begin
          state_next = fill_reset ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (command)
            CMD_INIT:  state_next = S_FILL;
            CMD_ALLOC: state_next = (bad_count || short_total) ? S_RESP : S_SCAN_RD;
            CMD_ALLOC_AT, CMD_FREE, CMD_QUERY: begin
              state_next = in_range ? S_BIT_RD : S_RESP;
            end
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      S_BIT_RD:   state_next = S_BIT_CHK;
      S_BIT_CHK:  state_next = S_RESP;
      S_SCAN_RD:  state_next = scan_beyond ? S_RESP : S_SCAN_CHK;
      S_SCAN_CHK: state_next = scan_enough ? S_PICK_RD : S_SCAN_RD;
      S_PICK_RD:  state_next = S_PICK_LD;
      S_PICK_LD:  state_next = S_PICK;
      S_PICK: begin
        if (!pick_go) begin
          state_next = (remaining == 5'd0) ? S_IDLE : S_PICK_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory access and result outputs
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = w[AW-1:0];
    mem_wdata   = orig;
    mem_raddr   = w[AW-1:0];
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_gid    = 32'd0;
    emit_free   = 1'b0;
    emit_last   = 1'b0;
    case (state)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_reset ? '1 : (taken_q ? '0 : cur_mask);
      end
      S_RESP: begin
        emit        = can_emit;
        emit_status = resp_status;
        emit_free   = resp_free;
        emit_last   = 1'b1;
      end
      S_BIT_RD: begin
        mem_raddr = bit_word;
      end
      S_BIT_CHK: begin
        mem_waddr = bit_word;
        if (cmd_q == CMD_ALLOC_AT && cur_bit) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~bit_onehot;
        end else if (cmd_q == CMD_FREE && !cur_bit) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | bit_onehot;
        end
      end
      S_PICK: begin
        if (pick_go) begin
          emit      = can_emit;
          emit_gid  = id_base + (word_base | 32'(pick_pos));
          emit_last = (remaining == 5'd1);
        end else begin
          // word done: write back with the granted bits cleared
          mem_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      w          <= '0;
      fill_reset <= 1'b1;
      free_total <= MW'(CAPACITY);
      id_base    <= 32'd0;
      id_count   <= 11'd1024;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_ID_BASE:  id_base  <= cfg_data;
          REG_ID_COUNT: id_count <= cfg_data[10:0];
          default: begin
          end
        endcase
      end

      if (emit) begin
        out_valid  <= 1'b1;
        status     <= emit_status;
        granted_id <= emit_gid;
        id_is_free <= emit_free;
        last       <= emit_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_FILL: begin
          w <= w + 1'b1;
          if (last_word && !fill_reset) begin
            free_total <= taken_q ? '0 : managed;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_q      <= command;
            cnt_q      <= count;
            taken_q    <= start_taken;
            idx_q      <= IW'(diff[31:0]);
            w          <= '0;
            acc        <= '0;
            fill_reset <= 1'b0;
            resp_free  <= 1'b0;
            case (command)
              CMD_ALLOC: begin
                if (bad_count) begin
                  resp_status <= ST_BAD_COUNT;
                end else if (short_total) begin
                  resp_status <= ST_NOT_ENOUGH;
                end else begin
                  resp_status <= ST_OK;
                end
              end
              CMD_ALLOC_AT, CMD_FREE, CMD_QUERY: begin
                resp_status <= in_range ? ST_OK : ST_OUT_OF_RANGE;
              end
              default: resp_status <= ST_OK;
            endcase
          end
        end
        S_BIT_CHK: begin
          case (cmd_q)
            CMD_ALLOC_AT: begin
              if (!cur_bit) begin
                resp_status <= ST_OCCUPIED;
              end else if (free_total != '0) begin
                free_total <= free_total - 1'b1;
              end
            end
            CMD_FREE: begin
              if (!cur_bit && (free_total < MW'(CAPACITY))) begin
                free_total <= free_total + 1'b1;
              end
            end
            CMD_QUERY: resp_free <= cur_bit;
            default: begin
            end
          endcase
        end
        S_SCAN_RD: begin
          if (scan_beyond) begin
            resp_status <= ST_NOT_ENOUGH;
          end
        end
        S_SCAN_CHK: begin
          if (scan_enough) begin
            w         <= '0;
            remaining <= cnt_q;
          end else begin
            w   <= w + 1'b1;
            acc <= scan_sum;
          end
        end
        S_PICK_LD: begin
          orig  <= mem_rdata;
          avail <= mem_rdata & cur_mask;
        end
        S_PICK: begin
          if (pick_go) begin
            if (can_emit) begin
              orig[pick_pos]  <= 1'b0;
              avail[pick_pos] <= 1'b0;
              remaining       <= remaining - 1'b1;
            end
          end else if (remaining == 5'd0) begin
            free_total <= free_total - MW'(cnt_q);
          end else begin
            w <= w + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
